FILE: sv/rlpm_pkg.sv
// Package for the ranked-list precision metrics block.
// Holds the metric codes, register indexes, configuration and divider status types.
// No dependencies.
package rlpm_pkg;

   // Widths that the register map and the running sum fix.
   localparam int CFG_W       = 16;
   localparam int SUM_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int MODE_W      = 2;

   // Defaults for the top-level parameters.
   localparam int COUNT_WIDTH_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;

   // Reset value of the rank cutoff.
   localparam logic [CFG_W-1:0] CUTOFF_RESET = 16'd10;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEVANT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONRELEVANT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOPIC_PRESENT = 3'd4;

   // Metric selected by the mode register.
   typedef enum logic [MODE_W-1:0] {
      MODE_AP        = 2'd0,
      MODE_RANK_EFF  = 2'd1,
      MODE_PREC_N    = 2'd2,
      MODE_SUCCESS_N = 2'd3
   } mode_type;

   // Configuration register contents.
   typedef struct packed {
      mode_type         mode;
      logic [CFG_W-1:0] relevant_count;
      logic [CFG_W-1:0] nonrelevant_count;
      logic [CFG_W-1:0] cutoff_n;
      logic             topic_present;
   } csr_type;

   // Status from the serial divider.
   typedef struct packed {
      logic done;
      logic overflow;
   } div_status_type;

endpackage

FILE: sv/ranked_list_precision_metrics_core.sv
// Ranked-list precision metrics: counts ranks and finds and reports one metric per list.
// Each item is taken in idle and passes ST_TERM; a relevant item in modes 0 and 1 may run
// a term division in the bit-serial divider before ST_ADD, and input waits until idle.
// An item marked last then passes ST_FINAL, may run a final division of 32 steps
// (modes 0 and 1) or 32 + FRACTION_BITS steps (mode 2), and ST_EMIT shows the result.
// Reset is synchronous: counts, sum and the result valid flag clear, registers take defaults.
module ranked_list_precision_metrics_core #(
   parameter int COUNT_WIDTH   = rlpm_pkg::COUNT_WIDTH_DEF,
   parameter int FRACTION_BITS = rlpm_pkg::FRACTION_BITS_DEF,
   localparam int RSP_DATA_W   = ((FRACTION_BITS + 8) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [0] assessed, [1] relevant
   input  logic                             req_tuser,  // [0] has_result
   input  logic                             req_tlast,  // last item of the list
   // Results.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]            rsp_tdata,  // [FRACTION_BITS:0] score
   output logic                             rsp_tuser,  // [0] divide_fault
   // Configuration writes.
   input  logic                             csr_wr_en,
   input  logic [rlpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rlpm_pkg::CFG_W-1:0]       csr_wdata
);
   import rlpm_pkg::*;

   localparam int DIV_W  = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
   localparam int TERM_W = FRACTION_BITS + 1;
   localparam int QUO_W  = FRACTION_BITS + 2;
   localparam int DVD_W  = SUM_W + FRACTION_BITS;
   localparam int STEP_W = $clog2(DVD_W + 1);
   localparam logic [TERM_W-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_TERM  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_ADD   = 7'b0001000,
      ST_FINAL = 7'b0010000,
      ST_FDIV  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   csr_type        csr_regs;
   div_status_type div_status;
   logic [QUO_W-1:0] div_quo;

   logic              div_start;
   logic [STEP_W-1:0] div_steps;
   logic [DIV_W-1:0]  div_rem_init;
   logic [DVD_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_divisor;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] rank_ff, rank_in;
   logic [COUNT_WIDTH-1:0] rel_ff, rel_in;
   logic [COUNT_WIDTH-1:0] nonrel_ff, nonrel_in;
   logic [COUNT_WIDTH-1:0] prior_nonrel_ff, prior_nonrel_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   past_cutoff_ff, past_cutoff_in;
   logic                   is_rel_ff, is_rel_in;
   logic                   last_ff, last_in;
   logic [TERM_W-1:0]      term_ff, term_in;
   logic [TERM_W-1:0]      score_ff, score_in;
   logic                   fault_ff, fault_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TERM_W-1:0]      rsp_score_ff, rsp_score_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic                   rsp_load;
   logic [SUM_W:0]         sum_wide;

   function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   rlpm_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_regs  (csr_regs)
   );

   rlpm_serial_div #(
      .DIV_W  (DIV_W),
      .DVD_W  (DVD_W),
      .QUO_W  (QUO_W),
      .STEP_W (STEP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_status)
   );

   // Add of the current term into the running sum; ST_ADD saturates it.
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(term_ff);

   // Sequencer: take an item, add a relevant item's term; on the last item score and report.
   always_comb begin
      state_in        = state_ff;
      rank_in         = rank_ff;
      rel_in          = rel_ff;
      nonrel_in       = nonrel_ff;
      prior_nonrel_in = prior_nonrel_ff;
      sum_in          = sum_ff;
      past_cutoff_in  = past_cutoff_ff;
      is_rel_in       = is_rel_ff;
      last_in         = last_ff;
      term_in         = term_ff;
      score_in        = score_ff;
      fault_in        = fault_ff;
      rsp_load        = 1'b0;
      div_start       = 1'b0;
      div_steps       = STEP_W'(FRACTION_BITS);
      div_rem_init    = '0;
      div_dividend    = '0;
      div_divisor     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               is_rel_in       = req_tuser & req_tdata[0] & req_tdata[1];
               last_in         = req_tlast;
               prior_nonrel_in = nonrel_ff;
               if (req_tuser) begin
                  rank_in = count_up(rank_ff);
                  past_cutoff_in = past_cutoff_ff |
                                   (DIV_W'(rank_in) > DIV_W'(csr_regs.cutoff_n));
                  if (req_tdata[0] && req_tdata[1]) begin
                     rel_in = count_up(rel_ff);
                  end else if (req_tdata[0]) begin
                     nonrel_in = count_up(nonrel_ff);
                  end
               end
               state_in = ST_TERM;
            end
         end

         ST_TERM: begin
            if (!is_rel_ff) begin
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_ADD;
               unique case (csr_regs.mode)
                  MODE_AP: begin
                     // Precision at this rank; a list with no miss so far gives 1.0.
                     if (rel_ff == rank_ff) begin
                        term_in = ONE_FIX;
                     end else begin
                        div_start    = 1'b1;
                        div_rem_init = DIV_W'(rel_ff);
                        div_divisor  = DIV_W'(rank_ff);
                        state_in     = ST_DIV;
                     end
                  end
                  MODE_RANK_EFF: begin
                     if (csr_regs.nonrelevant_count == '0) begin
                        term_in = ONE_FIX;
                     end else if (DIV_W'(prior_nonrel_ff) >=
                                  DIV_W'(csr_regs.nonrelevant_count)) begin
                        term_in = '0;
                     end else begin
                        div_start    = 1'b1;
                        div_rem_init = DIV_W'(prior_nonrel_ff);
                        div_divisor  = DIV_W'(csr_regs.nonrelevant_count);
                        state_in     = ST_DIV;
                     end
                  end
                  MODE_PREC_N, MODE_SUCCESS_N: begin
                     term_in = past_cutoff_ff ? '0 : TERM_W'(1);
                  end
               endcase
            end
         end

         ST_DIV: begin
            if (div_status.done) begin
               term_in  = (csr_regs.mode == MODE_AP) ? div_quo[TERM_W-1:0]
                                                     : ONE_FIX - div_quo[TERM_W-1:0];
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            state_in = last_ff ? ST_FINAL : ST_IDLE;
         end

         ST_FINAL: begin
            score_in     = '0;
            fault_in     = 1'b0;
            state_in     = ST_EMIT;
            div_dividend = {sum_ff, {FRACTION_BITS{1'b0}}};
            div_steps    = STEP_W'(SUM_W);
            div_divisor  = DIV_W'(csr_regs.relevant_count);
            if (csr_regs.topic_present) begin
               unique case (csr_regs.mode)
                  MODE_AP: begin
                     if (csr_regs.relevant_count != '0) begin
                        div_start = 1'b1;
                        state_in  = ST_FDIV;
                     end
                  end
                  MODE_RANK_EFF: begin
                     if (csr_regs.nonrelevant_count == '0) begin
                        score_in = ONE_FIX;
                     end else if (csr_regs.relevant_count == '0) begin
                        fault_in = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_FDIV;
                     end
                  end
                  MODE_PREC_N: begin
                     if (csr_regs.cutoff_n == '0) begin
                        fault_in = 1'b1;
                     end else begin
                        div_start   = 1'b1;
                        div_steps   = STEP_W'(DVD_W);
                        div_divisor = DIV_W'(csr_regs.cutoff_n);
                        state_in    = ST_FDIV;
                     end
                  end
                  MODE_SUCCESS_N: begin
                     score_in = (sum_ff != '0) ? ONE_FIX : '0;
                  end
               endcase
            end
         end

         ST_FDIV: begin
            if (div_status.done) begin
               // Scores above 1.0 saturate.
               score_in = (div_status.overflow || div_quo > QUO_W'(ONE_FIX)) ?
                          ONE_FIX : div_quo[TERM_W-1:0];
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load       = 1'b1;
               rank_in        = '0;
               rel_in         = '0;
               nonrel_in      = '0;
               sum_in         = '0;
               past_cutoff_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: a result waits here while the next list starts.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_fault_in = rsp_fault_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = score_ff;
         rsp_fault_in = fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rank_ff        <= '0;
         rel_ff         <= '0;
         nonrel_ff      <= '0;
         sum_ff         <= '0;
         past_cutoff_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rank_ff        <= rank_in;
         rel_ff         <= rel_in;
         nonrel_ff      <= nonrel_in;
         sum_ff         <= sum_in;
         past_cutoff_ff <= past_cutoff_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prior_nonrel_ff <= prior_nonrel_in;
      is_rel_ff       <= is_rel_in;
      last_ff         <= last_in;
      term_ff         <= term_in;
      score_ff        <= score_in;
      fault_ff        <= fault_in;
      rsp_score_ff    <= rsp_score_in;
      rsp_fault_ff    <= rsp_fault_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_score_ff);
   assign rsp_tuser  = rsp_fault_ff;

endmodule

FILE: sv/rlpm_csr_regs.sv
// Configuration registers of the ranked-list precision metrics block.
// Depends on rlpm_pkg for the register indexes and the csr_type struct.
module rlpm_csr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rlpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rlpm_pkg::CFG_W-1:0]         csr_wdata,
   output rlpm_pkg::csr_type                  csr_regs
);
   import rlpm_pkg::*;

   csr_type regs_ff;
   csr_type regs_in;

   // Decode one register write; indexes beyond the map are dropped.
   always_comb begin
      regs_in = regs_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:          regs_in.mode = mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_RELEVANT:      regs_in.relevant_count = csr_wdata;
            CSR_NONRELEVANT:   regs_in.nonrelevant_count = csr_wdata;
            CSR_CUTOFF:        regs_in.cutoff_n = csr_wdata;
            CSR_TOPIC_PRESENT: regs_in.topic_present = csr_wdata[0];
            default:           regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.mode              <= MODE_AP;
         regs_ff.relevant_count    <= '0;
         regs_ff.nonrelevant_count <= '0;
         regs_ff.cutoff_n          <= CUTOFF_RESET;
         regs_ff.topic_present     <= 1'b1;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_regs = regs_ff;

endmodule

FILE: sv/rlpm_serial_div.sv
// Radix-2 restoring divider that shifts the dividend in one bit per cycle.
// Depends on rlpm_pkg for the div_status_type struct.
module rlpm_serial_div #(
   parameter int DIV_W  = 16,
   parameter int DVD_W  = 48,
   parameter int QUO_W  = 18,
   parameter int STEP_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [STEP_W-1:0]           steps,
   input  logic [DIV_W-1:0]            rem_init,
   input  logic [DVD_W-1:0]            dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic [QUO_W-1:0]            quotient,
   output rlpm_pkg::div_status_type    status
);
   import rlpm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;

   // One compare-and-subtract step on the partial remainder.
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign ge    = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      ovf_in     = ovf_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         ovf_in     = 1'b0;
         cnt_in     = steps;
         rem_in     = rem_init;
         divisor_in = divisor;
         dvd_in     = dividend;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         // A quotient bit pushed off the top marks a result far above 1.0.
         ovf_in = ovf_ff | quo_ff[QUO_W-1];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff     <= ovf_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
   end

   assign quotient        = quo_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule

FILE: sv/rlpm_checker.sv
// Port-level checks for the ranked-list precision metrics block.
// Bound to ranked_list_precision_metrics_core; needs no package.
module rlpm_checker #(
   parameter int FRACTION_BITS = 16,
   localparam int RSP_DATA_W   = ((FRACTION_BITS + 8) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   localparam logic [RSP_DATA_W-1:0] ONE_FIX = RSP_DATA_W'(1) << FRACTION_BITS;

   // No result is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A divide fault always comes with a zero score.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("divide fault with nonzero score");

   // Scores never exceed 1.0.
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= ONE_FIX)
      else $error("score above 1.0");

   // Each input transfer keeps the block busy for at least the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on consecutive cycles");

endmodule

bind ranked_list_precision_metrics_core rlpm_checker #(
   .FRACTION_BITS (FRACTION_BITS)
) u_rlpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/tb_top.sv
// Self-checking bench for ranked_list_precision_metrics_core: directed lists, a longer list
// of misses, a stretch of receiver hold-off, then random lists under random idling.
// Depends on rlpm_pkg and the core module only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rlpm_pkg::*;

   localparam int FRAC         = FRACTION_BITS_DEF;
   localparam int COUNT_W      = COUNT_WIDTH_DEF;
   localparam int RSP_W        = ((FRAC + 8) / 8) * 8;
   localparam int SETTLE_WAIT  = 100;     // final division plus slack
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int IDLE_LIMIT   = 2000;    // cycles without any transfer
   localparam int RANDOM_ITEMS = 850;
   localparam int LONG_LIST    = 40;      // misses ahead of the relevant finds
   localparam longint unsigned UNITY   = 64'd1 << FRAC;
   localparam longint unsigned SUM_TOP = 64'hFFFF_FFFF;

   typedef struct packed {
      logic has;
      logic assessed;
      logic relevant;
      logic last;
   } req_item_type;

   typedef struct packed {
      logic [FRAC:0] score;
      logic          fault;
   } metric_type;

   // Expected value typed into a directed row, carried along with the item.
   typedef struct packed {
      logic       known;
      metric_type val;
   } tag_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CFG_W-1:0]       value;
      req_item_type           item;
      tag_type                tag;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [0] assessed, [1] relevant
   logic                   req_tuser;   // [0] has_result
   logic                   req_tlast;   // last item of the list
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;   // [FRAC:0] score
   logic                   rsp_tuser;   // [0] divide_fault
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   // Register copies and list state of the predictor.
   mode_type           cfg_mode;
   logic [CFG_W-1:0]   cfg_rel;
   logic [CFG_W-1:0]   cfg_nonrel;
   logic [CFG_W-1:0]   cfg_cutoff;
   logic               cfg_topic;
   logic [COUNT_W-1:0] rank_seen;
   logic [COUNT_W-1:0] rel_found;
   logic [COUNT_W-1:0] nonrel_found;
   logic [SUM_W-1:0]   psum;
   logic               past_cutoff;

   metric_type awaited_scores[$];
   tag_type    item_tags[$];
   int         mismatches;
   int         idle_cycles;
   int         counted;
   bit         long_hold_due;

   ranked_list_precision_metrics_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned clamp_one(input longint unsigned v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   function automatic req_item_type pack_item(input bit h, input bit a, input bit r,
                                              input bit l);
      req_item_type it;
      it.has = h;
      it.assessed = a;
      it.relevant = r;
      it.last = l;
      return it;
   endfunction

   function automatic row_type cfg_row(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
      row_type row;
      row = '{kind: ROW_CFG, index: idx, value: val, item: '0, tag: '0};
      return row;
   endfunction

   function automatic row_type item_row(input bit h, input bit a, input bit r, input bit l);
      row_type row;
      row = '{kind: ROW_ITEM, index: '0, value: '0, item: pack_item(h, a, r, l), tag: '0};
      return row;
   endfunction

   function automatic row_type known_row(input bit h, input bit a, input bit r, input bit l,
                                         input longint unsigned score, input bit fault);
      row_type row;
      row = item_row(h, a, r, l);
      row.tag.known = 1'b1;
      row.tag.val.score = score[FRAC:0];
      row.tag.val.fault = fault;
      return row;
   endfunction

   // Advances the list state by one item; returns 1 with the metric when the item ends a list.
   function automatic bit score_item(input req_item_type it, output metric_type res);
      logic [COUNT_W-1:0] prior_nonrel;
      longint unsigned    num;
      longint unsigned    quot;
      longint unsigned    term;
      bit                 hit;
      res = '0;
      prior_nonrel = nonrel_found;
      hit = it.assessed && it.relevant;
      term = 64'd0;
      if (it.has) begin
         if (rank_seen != '1) rank_seen = rank_seen + 1'b1;
         if (rank_seen > cfg_cutoff) past_cutoff = 1'b1;
         if (hit) begin
            if (rel_found != '1) rel_found = rel_found + 1'b1;
         end else if (it.assessed) begin
            if (nonrel_found != '1) nonrel_found = nonrel_found + 1'b1;
         end
         if (hit) begin
            case (cfg_mode)
               MODE_AP: begin
                  num = 64'(rel_found);
                  term = clamp_one((num << FRAC) / 64'(rank_seen));
               end
               MODE_RANK_EFF: begin
                  if (cfg_nonrel == '0) begin
                     term = UNITY;
                  end else begin
                     num = 64'(prior_nonrel);
                     quot = (num << FRAC) / 64'(cfg_nonrel);
                     term = (quot >= UNITY) ? 64'd0 : UNITY - quot;
                  end
               end
               default: term = past_cutoff ? 64'd0 : 64'd1;
            endcase
            num = 64'(psum);
            num = num + term;
            psum = (num > SUM_TOP) ? '1 : num[SUM_W-1:0];
         end
      end
      if (!it.last) return 1'b0;

      // The report uses the registers in force at the last item.
      if (cfg_topic) begin
         num = 64'(psum);
         case (cfg_mode)
            MODE_AP: begin
               if (cfg_rel != '0) res.score = (FRAC+1)'(clamp_one(num / 64'(cfg_rel)));
            end
            MODE_RANK_EFF: begin
               if (cfg_nonrel == '0) res.score = (FRAC+1)'(UNITY);
               else if (cfg_rel == '0) res.fault = 1'b1;
               else res.score = (FRAC+1)'(clamp_one(num / 64'(cfg_rel)));
            end
            MODE_PREC_N: begin
               if (cfg_cutoff == '0) res.fault = 1'b1;
               else res.score = (FRAC+1)'(clamp_one((num << FRAC) / 64'(cfg_cutoff)));
            end
            default: res.score = (num != 64'd0) ? (FRAC+1)'(UNITY) : '0;
         endcase
      end
      rank_seen = '0;
      rel_found = '0;
      nonrel_found = '0;
      psum = '0;
      past_cutoff = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Checks result transfers against the oldest expectation, then predicts from input transfers.
   always @(posedge clock) begin : score_check
      metric_type want;
      metric_type pred;
      tag_type    tag;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_scores.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_tdata), 32'd0);
            end else begin
               want = awaited_scores.pop_front();
               if (rsp_tdata !== RSP_W'(want.score))
                  report_mismatch("score", 32'(rsp_tdata), 32'(want.score));
               if (rsp_tuser !== want.fault)
                  report_mismatch("divide_fault", 32'(rsp_tuser), 32'(want.fault));
            end
         end
         if (req_tvalid && req_tready) begin
            tag = item_tags.pop_front();
            if (score_item(pack_item(req_tuser, req_tdata[0], req_tdata[1], req_tlast), pred))
               awaited_scores.push_back(tag.known ? tag.val : pred);
         end
      end
   end

   // Watchdog on cycles that carry no transfer on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result receiver: random stalls, quiet stretches, and one long hold-off on request.
   initial begin : rsp_sink
      int unsigned stall;
      int          calm;
      rsp_tready = 1'b0;
      calm = 0;
      @(negedge clock);
      forever begin
         if (long_hold_due) begin
            stall = HOLD_CYCLES;
            long_hold_due = 1'b0;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 20);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Offers one item after a gap and returns at the falling edge after its transfer.
   task automatic offer(input req_item_type it, input int unsigned gap, input tag_type tag);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= it.has;
      req_tdata <= {6'b0, it.relevant, it.assessed};
      req_tlast <= it.last;
      req_tvalid <= 1'b1;
      item_tags.push_back(tag);
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Waits until every result is in and the core has had time to finish trailing work.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_scores.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Drives one register write and mirrors it; the caller lowers the enable after a burst.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:          cfg_mode = mode_type'(val[MODE_W-1:0]);
         CSR_RELEVANT:      cfg_rel = val;
         CSR_NONRELEVANT:   cfg_nonrel = val;
         CSR_CUTOFF:        cfg_cutoff = val;
         CSR_TOPIC_PRESENT: cfg_topic = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_count();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CFG_W'(1);
         2: return '1;
         3, 4: return CFG_W'($urandom_range(1, 20));
         default: return CFG_W'($urandom());
      endcase
   endfunction

   // One random list: mostly ranked documents, some empty markers mixed in as noise.
   task automatic run_list(input int len, input bit finish, input bit burst);
      req_item_type it;
      for (int k = 0; k < len; k++) begin
         it.has = ($urandom_range(0, 9) != 0);
         it.assessed = ($urandom_range(0, 4) != 0);
         it.relevant = $urandom_range(0, 1);
         it.last = finish && (k == len - 1);
         if (it.has || it.last) counted++;
         offer(it, burst ? 0 : $urandom_range(0, 9), '0);
      end
   endtask

   initial begin : stimulus
      row_type plan[$];
      int      lists;
      int      len;
      bit      burst;
      bit      unfinished;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      idle_cycles = 0;
      counted = 0;
      long_hold_due = 1'b0;
      cfg_mode = MODE_AP;
      cfg_rel = '0;
      cfg_nonrel = '0;
      cfg_cutoff = CUTOFF_RESET;
      cfg_topic = 1'b1;
      rank_seen = '0;
      rel_found = '0;
      nonrel_found = '0;
      psum = '0;
      past_cutoff = 1'b0;

      // After reset, average precision with no relevant documents reports zero.
      plan.push_back(known_row(0, 0, 0, 1, 0, 0));
      // One relevant document at rank one gives exactly 1.0.
      plan.push_back(cfg_row(CSR_RELEVANT, 1));
      plan.push_back(known_row(1, 1, 1, 1, UNITY, 0));
      // Rank effectiveness with no nonrelevant documents is 1.0.
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_RANK_EFF)));
      plan.push_back(known_row(1, 1, 1, 1, UNITY, 0));
      // A nonrelevant find ahead of the relevant one lowers its term.
      plan.push_back(cfg_row(CSR_NONRELEVANT, 4));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 0, 1, 0));
      plan.push_back(item_row(1, 1, 1, 1));
      // No relevant documents in rank effectiveness is a divide fault.
      plan.push_back(cfg_row(CSR_RELEVANT, 0));
      plan.push_back(known_row(1, 1, 1, 1, 0, 1));
      // Precision at n with a zero cutoff is a divide fault.
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_PREC_N)));
      plan.push_back(cfg_row(CSR_CUTOFF, 0));
      plan.push_back(known_row(1, 1, 1, 1, 0, 1));
      // Cutoff of two: the third rank falls past it, flags on the end marker are ignored.
      plan.push_back(cfg_row(CSR_CUTOFF, 2));
      plan.push_back(item_row(1, 1, 1, 0));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 1, 1, 0));
      plan.push_back(item_row(0, 1, 1, 1));
      // Success at n where the only relevant document lies past the cutoff.
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_SUCCESS_N)));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 1, 1, 1));
      // A missing topic forces zero.
      plan.push_back(cfg_row(CSR_TOPIC_PRESENT, 0));
      plan.push_back(known_row(1, 1, 1, 1, 0, 0));
      // More nonrelevant finds than judged make the rank effectiveness term zero.
      plan.push_back(cfg_row(CSR_TOPIC_PRESENT, 1));
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_RANK_EFF)));
      plan.push_back(cfg_row(CSR_NONRELEVANT, 1));
      plan.push_back(cfg_row(CSR_RELEVANT, 1));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 1, 0, 0));
      plan.push_back(item_row(1, 1, 1, 1));
      // Two relevant documents against a judged count of one saturate at 1.0.
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_AP)));
      plan.push_back(item_row(1, 1, 1, 0));
      plan.push_back(known_row(1, 1, 1, 1, UNITY, 0));
      // Mode change in the middle of a list: a precision-at-n term, then an AP term.
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_PREC_N)));
      plan.push_back(cfg_row(CSR_CUTOFF, 10));
      plan.push_back(item_row(1, 1, 1, 0));
      plan.push_back(cfg_row(CSR_MODE, CFG_W'(MODE_AP)));
      plan.push_back(cfg_row(CSR_RELEVANT, 2));
      plan.push_back(item_row(1, 1, 1, 1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows; register writes only once the core has gone quiet.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            if (i == 0 || plan[i-1].kind != ROW_CFG) settle();
            write_reg(plan[i].index, plan[i].value);
            if (i == plan.size() - 1 || plan[i+1].kind != ROW_CFG) csr_wr_en <= 1'b0;
         end else begin
            offer(plan[i].item, $urandom_range(0, 9), plan[i].tag);
         end
      end

      // A longer run of misses ahead of three relevant finds.
      settle();
      write_reg(CSR_MODE, CFG_W'(MODE_AP));
      write_reg(CSR_RELEVANT, 3);
      write_reg(CSR_NONRELEVANT, 100);
      csr_wr_en <= 1'b0;
      repeat (LONG_LIST) offer(pack_item(1, 1, 0, 0), 0, '0);
      offer(pack_item(1, 1, 1, 0), 0, '0);
      offer(pack_item(1, 1, 1, 0), 0, '0);
      offer(pack_item(1, 1, 1, 1), 0, '0);

      // The receiver holds off while short lists keep coming, so the core fills and stalls.
      settle();
      long_hold_due = 1'b1;
      repeat (4) run_list(3, 1'b1, 1'b1);

      // Random phases: fresh registers, a few lists, now and then one left open.
      while (counted < RANDOM_ITEMS) begin
         settle();
         write_reg(CSR_MODE, CFG_W'($urandom()));
         write_reg(CSR_RELEVANT, pick_count());
         write_reg(CSR_NONRELEVANT, pick_count());
         case ($urandom_range(0, 4))
            0: write_reg(CSR_CUTOFF, '0);
            1: write_reg(CSR_CUTOFF, '1);
            2: write_reg(CSR_CUTOFF, CFG_W'($urandom()));
            default: write_reg(CSR_CUTOFF, CFG_W'($urandom_range(1, 30)));
         endcase
         write_reg(CSR_TOPIC_PRESENT,
                   CFG_W'($urandom_range(0, 7) != 0) | CFG_W'({$urandom()} & ~32'd1));
         // Writes to unmapped indexes must leave every register alone.
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(CSR_TOPIC_PRESENT + 1,
                                                  (1 << CSR_INDEX_W) - 1)),
                      CFG_W'($urandom()));
         csr_wr_en <= 1'b0;
         burst = ($urandom_range(0, 4) == 0);
         lists = $urandom_range(1, 4);
         for (int l = 0; l < lists; l++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 12);
            unfinished = (l == lists - 1) && ($urandom_range(0, 9) == 0);
            run_list(len, !unfinished, burst);
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
